@@ rtl/ffoa_pkg.sv @@
// Package for the first-fit offset allocator.
// Holds the shared widths, command and status codes and the sequencer state type.
// Has no dependencies; ffoa_alu and the top level use it by scoped names.
package ffoa_pkg;

    localparam int DATA_W     = 32;
    localparam int ID_FIELD_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;

    localparam logic CMD_CLAIM   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_CMP,
        ST_C_ADV,
        ST_UP_PRIME,
        ST_UP,
        ST_INSERT,
        ST_R_CMP,
        ST_DN_PRIME,
        ST_DN,
        ST_FINISH,
        ST_RESP
    } t_state;

endpackage

@@ rtl/ffoa_table.sv @@
// Entry store of the allocator: one write port and one registered read port.
// Each entry packs offset, size and owner id; it has no package dependencies.
// Contents are undefined until written; the sequencer tracks the live count.
module ffoa_table #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ffoa_alu.sv @@
// Shared add and compare unit of the allocator sequencer.
// Gives a + b with carry and whether that sum is at most c; uses ffoa_pkg widths.
module ffoa_alu (
    input  logic [ffoa_pkg::DATA_W-1:0] i_a,
    input  logic [ffoa_pkg::DATA_W-1:0] i_b,
    input  logic [ffoa_pkg::DATA_W-1:0] i_c,
    output logic [ffoa_pkg::DATA_W:0]   o_sum,
    output logic                        o_le
);

    assign o_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_le  = (o_sum <= {1'b0, i_c});

endmodule

@@ rtl/first_fit_offset_allocator.sv @@
// Top level of the first-fit offset allocator: sequencer, result register and assertions.
// Instantiates ffoa_table and ffoa_alu; uses ffoa_pkg types and constants.
//
//  Channel  | Direction | tdata (low bit up)                   | tuser
//  s_axis   | in        | tensor_id[15:0], block_size[47:16]   | command[0]
//  m_axis   | out       | placed_offset[31:0], high_water[63:32]| status[1:0]
//
// A claim tests the gap before each live slot in turn on the shared adder, a compare and
// then an advance per gap; it then moves every later entry up one slot and writes the new one.
// A release scans for the id (not found if it is not live), then moves every later entry
// down one slot; a claim into a full table is refused at once, one that overflows after its gap tests.
// The entry store has one read and one write port, so entries are moved one by one.
// Reset clears the live count, the high-water mark and the sequencer; no clearing pass.
// s_axis_tready is high only while idle; a finished result waits in the output register.
module first_fit_offset_allocator #(
    parameter int TABLE_ENTRIES = 32,
    parameter int ID_BITS       = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tensor_id [15:0], block_size [47:16]
    input  logic [ffoa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command [0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // placed_offset [31:0], high_water [63:32]
    output logic [ffoa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // status [1:0]
    output logic [1:0]                        m_axis_tuser
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int DW      = ffoa_pkg::DATA_W;
    localparam int ENTRY_W = 2 * DW + ID_BITS;

    ffoa_pkg::t_state  r_state;
    ffoa_pkg::t_state  n_state;
    ffoa_pkg::t_status r_status;

    logic [ID_BITS-1:0] r_id;
    logic [DW-1:0]      r_req;
    logic [DW-1:0]      r_cursor;
    logic [DW-1:0]      r_end;
    logic [DW-1:0]      r_offset;
    logic [DW-1:0]      r_peak;
    logic [CNT_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_cnt;

    logic                       r_m_valid;
    logic [ffoa_pkg::M_TDATA_W-1:0] r_m_data;
    logic [1:0]                 r_m_user;

    logic               w_accept;
    logic               w_full;
    logic               w_out_free;
    logic [DW-1:0]      w_in_size;
    logic [CNT_W:0]     w_pos_x;
    logic [CNT_W:0]     w_i_x;
    logic [CNT_W:0]     w_cnt_x;
    logic               w_scan_end;
    logic               w_hit;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [CNT_W:0]     w_raddr_x;
    logic [ENTRY_W-1:0] w_rdata;
    logic [DW-1:0]      w_rd_off;
    logic [DW-1:0]      w_rd_size;
    logic [ID_BITS-1:0] w_rd_owner;

    logic [DW-1:0]      w_alu_a;
    logic [DW-1:0]      w_alu_b;
    logic [DW-1:0]      w_alu_c;
    logic [DW:0]        w_sum;
    logic               w_le;

    ffoa_table #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_x[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    ffoa_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_c   (w_alu_c),
        .o_sum (w_sum),
        .o_le  (w_le)
    );

    assign s_axis_tready = (r_state == ffoa_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_cnt == CNT_W'(TABLE_ENTRIES));
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_in_size     = s_axis_tdata[ffoa_pkg::ID_FIELD_W +: DW];

    assign w_pos_x = {1'b0, r_pos};
    assign w_i_x   = {1'b0, r_i};
    assign w_cnt_x = {1'b0, r_cnt};

    assign w_rd_off   = w_rdata[DW-1:0];
    assign w_rd_size  = w_rdata[2*DW-1:DW];
    assign w_rd_owner = w_rdata[2*DW +: ID_BITS];

    assign w_scan_end = (r_pos == r_cnt);
    assign w_hit      = (w_rd_owner == r_id);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffoa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0] == ffoa_pkg::CMD_RELEASE) begin
                        n_state = ffoa_pkg::ST_R_CMP;
                    end else if (w_full) begin
                        n_state = ffoa_pkg::ST_RESP;
                    end else begin
                        n_state = ffoa_pkg::ST_C_CMP;
                    end
                end
            end
            ffoa_pkg::ST_C_CMP: begin
                if (w_scan_end || w_le) begin
                    n_state = w_sum[DW] ? ffoa_pkg::ST_RESP : ffoa_pkg::ST_UP_PRIME;
                end else begin
                    n_state = ffoa_pkg::ST_C_ADV;
                end
            end
            ffoa_pkg::ST_C_ADV: begin
                n_state = ffoa_pkg::ST_C_CMP;
            end
            ffoa_pkg::ST_UP_PRIME: begin
                n_state = (r_pos < r_cnt) ? ffoa_pkg::ST_UP : ffoa_pkg::ST_INSERT;
            end
            ffoa_pkg::ST_UP: begin
                n_state = ((r_i - CNT_W'(1)) > r_pos) ? ffoa_pkg::ST_UP : ffoa_pkg::ST_INSERT;
            end
            ffoa_pkg::ST_INSERT: begin
                n_state = ffoa_pkg::ST_RESP;
            end
            ffoa_pkg::ST_R_CMP: begin
                priority if (w_scan_end) begin
                    n_state = ffoa_pkg::ST_RESP;
                end else if (w_hit) begin
                    n_state = ffoa_pkg::ST_DN_PRIME;
                end
            end
            ffoa_pkg::ST_DN_PRIME: begin
                n_state = ((w_pos_x + (CNT_W+1)'(1)) < w_cnt_x) ? ffoa_pkg::ST_DN
                                                                 : ffoa_pkg::ST_FINISH;
            end
            ffoa_pkg::ST_DN: begin
                n_state = ((w_i_x + (CNT_W+1)'(2)) < w_cnt_x) ? ffoa_pkg::ST_DN
                                                               : ffoa_pkg::ST_FINISH;
            end
            ffoa_pkg::ST_FINISH: begin
                n_state = ffoa_pkg::ST_RESP;
            end
            ffoa_pkg::ST_RESP: begin
                if (w_out_free) begin
                    n_state = ffoa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_i[IDX_W-1:0];
        w_wdata   = w_rdata;
        w_raddr_x = w_pos_x;
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_c   = '0;
        unique case (r_state)
            ffoa_pkg::ST_IDLE: begin
                w_raddr_x = '0;
            end
            ffoa_pkg::ST_C_CMP: begin
                w_alu_a = r_cursor;
                w_alu_b = r_req;
                w_alu_c = w_rd_off;
            end
            ffoa_pkg::ST_C_ADV: begin
                w_alu_a   = w_rd_off;
                w_alu_b   = w_rd_size;
                w_raddr_x = w_pos_x + (CNT_W+1)'(1);
            end
            ffoa_pkg::ST_UP_PRIME: begin
                w_raddr_x = w_cnt_x - (CNT_W+1)'(1);
            end
            ffoa_pkg::ST_UP: begin
                w_we      = 1'b1;
                w_raddr_x = w_i_x - (CNT_W+1)'(2);
            end
            ffoa_pkg::ST_INSERT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[IDX_W-1:0];
                w_wdata = {r_id, r_req, r_cursor};
                w_alu_a = r_peak;
                w_alu_c = r_end;
            end
            ffoa_pkg::ST_R_CMP: begin
                if (!w_scan_end && !w_hit) begin
                    w_raddr_x = w_pos_x + (CNT_W+1)'(1);
                end
            end
            ffoa_pkg::ST_DN_PRIME: begin
                w_raddr_x = w_pos_x + (CNT_W+1)'(1);
            end
            ffoa_pkg::ST_DN: begin
                w_we      = 1'b1;
                w_raddr_x = w_i_x + (CNT_W+1)'(2);
            end
            ffoa_pkg::ST_FINISH, ffoa_pkg::ST_RESP: begin
                w_raddr_x = w_pos_x;
            end
            default: begin
                w_raddr_x = w_pos_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_peak <= '0;
        end else begin
            if (r_state == ffoa_pkg::ST_INSERT) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_le) begin
                    r_peak <= r_end;
                end
            end else if (r_state == ffoa_pkg::ST_FINISH) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ffoa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_id     <= ID_BITS'(s_axis_tdata[ffoa_pkg::ID_FIELD_W-1:0]);
                    r_req    <= (w_in_size == '0) ? DW'(1) : w_in_size;
                    r_cursor <= '0;
                    r_pos    <= '0;
                    r_offset <= '0;
                    if ((s_axis_tuser[0] == ffoa_pkg::CMD_CLAIM) && w_full) begin
                        r_status <= ffoa_pkg::STATUS_FULL;
                    end else begin
                        r_status <= ffoa_pkg::STATUS_OK;
                    end
                end
            end
            ffoa_pkg::ST_C_CMP: begin
                if (w_scan_end || w_le) begin
                    r_end <= w_sum[DW-1:0];
                    if (w_sum[DW]) begin
                        r_status <= ffoa_pkg::STATUS_OVERFLOW;
                    end
                end
            end
            ffoa_pkg::ST_C_ADV: begin
                r_cursor <= w_sum[DW-1:0];
                r_pos    <= r_pos + CNT_W'(1);
            end
            ffoa_pkg::ST_UP_PRIME: begin
                r_i <= r_cnt;
            end
            ffoa_pkg::ST_UP: begin
                r_i <= r_i - CNT_W'(1);
            end
            ffoa_pkg::ST_INSERT: begin
                r_offset <= r_cursor;
            end
            ffoa_pkg::ST_R_CMP: begin
                priority if (w_scan_end) begin
                    r_status <= ffoa_pkg::STATUS_NOT_FOUND;
                end else if (!w_hit) begin
                    r_pos <= r_pos + CNT_W'(1);
                end
            end
            ffoa_pkg::ST_DN_PRIME: begin
                r_i <= r_pos;
            end
            ffoa_pkg::ST_DN: begin
                r_i <= r_i + CNT_W'(1);
            end
            ffoa_pkg::ST_FINISH, ffoa_pkg::ST_RESP: begin
                r_end <= r_end;
            end
            default: begin
                r_end <= r_end;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ffoa_pkg::ST_RESP) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ffoa_pkg::ST_RESP) && w_out_free) begin
            r_m_data <= {r_peak, r_offset};
            r_m_user <= r_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_ENTRIES))
        else $error("live count exceeds the table depth");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_peak >= $past(r_peak)))
        else $error("high-water mark fell");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + CNT_W'(1))
                            || (r_cnt + CNT_W'(1) == $past(r_cnt))))
        else $error("live count changed by more than one");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != ffoa_pkg::ST_IDLE))
        else $error("sequencer stayed idle after a transaction");

endmodule
